FILE: hdl/bds_pkg.sv
// Package for the battery discharge statistics block: request and response
// payload types, sequencer states, accumulator control and fixed constants.
// No dependencies.
`default_nettype none

package bds_pkg;

   localparam int PERIOD_W     = 12;
   localparam int SUM_W        = 64;
   localparam int DELIVERED_W  = 48;
   localparam int PEAK_W       = 31;
   localparam int DESIGN_W     = 32;

   localparam logic [PERIOD_W-1:0]    PERIOD_RESET  = 12'd7;
   localparam logic [PEAK_W-1:0]      MAX31         = 31'h7FFF_FFFF;
   localparam logic [31:0]            MAX32         = 32'hFFFF_FFFF;
   localparam logic [DELIVERED_W-1:0] MAX48         = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0]            HEALTH_MAX    = 16'hFFFF;
   localparam logic [9:0]             PERMILLE      = 10'd1000;

   typedef struct packed {
      logic [15:0] voltage_mv;
      logic signed [31:0] rate_mw;
      logic [31:0] remaining_mwh;
      logic [31:0] design_mwh;
      logic [15:0] temperature_dk;
      logic        last_sample;
   } req_type;

   typedef struct packed {
      logic        report_valid;
      logic [31:0] sample_total;
      logic [31:0] runtime_s;
      logic [47:0] delivered_energy_mwh;
      logic [30:0] avg_discharge_mw;
      logic [30:0] max_discharge_mw;
      logic [15:0] min_voltage_out_mv;
      logic [15:0] max_temperature_out_dk;
      logic [15:0] health_tenth_pct;
   } rsp_type;

   typedef struct packed {
      logic sample;
      logic clear;
   } acc_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_HEALTH_START,
      ST_HEALTH_WAIT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/bds_divider.sv
// Shared restoring divider: one quotient bit per cycle, NUM_W steps per divide.
// Depends on nothing; used by the top level for both report quotients.
`default_nettype none

module bds_divider #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numerator,
   input  wire logic [DEN_W-1:0] denominator,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             take;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      take    = (trial >= {1'b0, den_ff});
      rem_in  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in  = {quo_ff[NUM_W-2:0], take};
      done_in = (cnt_ff == CNT_W'(1));
      if (start) begin
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/bds_accum.sv
// Per-sample statistics registers: counts, extremes, discharge sums and
// delivered energy, updated on each accepted request. Depends on bds_pkg.
`default_nettype none

module bds_accum #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bds_pkg::acc_ctrl_type ctrl,
   input  wire bds_pkg::req_type      sample,
   output logic [COUNT_WIDTH-1:0]     sample_counter,
   output logic [15:0]                lowest_voltage,
   output logic [15:0]                highest_temperature,
   output logic [63:0]                discharge_sum,
   output logic [COUNT_WIDTH-1:0]     discharge_count,
   output logic [30:0]                discharge_peak,
   output logic [47:0]                delivered_sum,
   output logic [31:0]                latest_design
);

   import bds_pkg::*;

   logic [COUNT_WIDTH-1:0] scount_ff, scount_in;
   logic [15:0]            low_ff, low_in;
   logic [15:0]            high_ff, high_in;
   logic [SUM_W-1:0]       dsum_ff, dsum_in;
   logic [COUNT_WIDTH-1:0] dcount_ff, dcount_in;
   logic [PEAK_W-1:0]      peak_ff, peak_in;
   logic [DELIVERED_W-1:0] deliv_ff, deliv_in;
   logic [31:0]            prev_ff, prev_in;
   logic [DESIGN_W-1:0]    design_ff, design_in;
   logic                   seen_ff, seen_in;

   logic [31:0]            neg_rate;
   logic [PEAK_W-1:0]      mag;
   logic [SUM_W:0]         dsum_add;
   logic [DELIVERED_W:0]   deliv_add;
   logic [31:0]            drop;

   always_comb begin
      neg_rate  = 32'(~sample.rate_mw) + 32'd1;
      mag       = neg_rate[31] ? MAX31 : neg_rate[30:0];
      dsum_add  = {1'b0, dsum_ff} + (SUM_W + 1)'(mag);
      drop      = prev_ff - sample.remaining_mwh;
      deliv_add = {1'b0, deliv_ff} + (DELIVERED_W + 1)'(drop);

      scount_in = scount_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      dsum_in   = dsum_ff;
      dcount_in = dcount_ff;
      peak_in   = peak_ff;
      deliv_in  = deliv_ff;
      prev_in   = prev_ff;
      design_in = design_ff;
      seen_in   = seen_ff;

      if (ctrl.clear) begin
         scount_in = '0;
         low_in    = '0;
         high_in   = '0;
         dsum_in   = '0;
         dcount_in = '0;
         peak_in   = '0;
         deliv_in  = '0;
         prev_in   = '0;
         design_in = '0;
         seen_in   = 1'b0;
      end else if (ctrl.sample) begin
         if (!seen_ff) begin
            low_in = sample.voltage_mv;
         end else begin
            if (sample.voltage_mv < low_ff) begin
               low_in = sample.voltage_mv;
            end
            if (prev_ff > sample.remaining_mwh) begin
               deliv_in = deliv_add[DELIVERED_W] ? MAX48 : deliv_add[DELIVERED_W-1:0];
            end
         end
         if (sample.temperature_dk > high_ff) begin
            high_in = sample.temperature_dk;
         end
         if (sample.rate_mw[31]) begin
            dsum_in = dsum_add[SUM_W] ? '1 : dsum_add[SUM_W-1:0];
            if (dcount_ff != '1) begin
               dcount_in = dcount_ff + COUNT_WIDTH'(1);
            end
            if (mag > peak_ff) begin
               peak_in = mag;
            end
         end
         prev_in   = sample.remaining_mwh;
         design_in = sample.design_mwh;
         seen_in   = 1'b1;
         if (scount_ff != '1) begin
            scount_in = scount_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scount_ff <= '0;
         low_ff    <= '0;
         high_ff   <= '0;
         dsum_ff   <= '0;
         dcount_ff <= '0;
         peak_ff   <= '0;
         deliv_ff  <= '0;
         prev_ff   <= '0;
         design_ff <= '0;
         seen_ff   <= 1'b0;
      end else begin
         scount_ff <= scount_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         dsum_ff   <= dsum_in;
         dcount_ff <= dcount_in;
         peak_ff   <= peak_in;
         deliv_ff  <= deliv_in;
         prev_ff   <= prev_in;
         design_ff <= design_in;
         seen_ff   <= seen_in;
      end
   end

   assign sample_counter      = scount_ff;
   assign lowest_voltage      = low_ff;
   assign highest_temperature = high_ff;
   assign discharge_sum       = dsum_ff;
   assign discharge_count     = dcount_ff;
   assign discharge_peak      = peak_ff;
   assign delivered_sum       = deliv_ff;
   assign latest_design       = design_ff;

endmodule

`default_nettype wire

FILE: hdl/battery_discharge_statistics.sv
// Top level of the battery discharge statistics block: sequencer, sample
// period register and response register. Depends on bds_pkg, bds_accum
// and bds_divider.
//
// Usage:
//  - req_* carries one logged battery sample per request; req_data.last_sample
//    closes a log. rsp_* carries one report per closed log. csr_* writes the
//    sample period in seconds and is always ready.
//  - A request without last_sample is folded into the statistics;
//    req_ready stays high, so such requests go one per cycle.
//  - A request with last_sample starts the report: two quotients (mean
//    discharge and health) run one after the other through one shared
//    divider that yields one quotient bit per cycle, 64 bits each. A
//    quotient whose divisor is zero is skipped; req_ready is low until
//    the report is loaded into the response register.
//  - The report waits in the response register until rsp_ready; further
//    samples are taken meanwhile, and the next report waits for the register
//    to empty. The statistics clear once the report is loaded.
//  - Reset (synchronous, active high) clears the statistics, empties the
//    response register and sets the sample period to 7 s.
`default_nettype none

module battery_discharge_statistics #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bds_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bds_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [11:0]      csr_data
);

   import bds_pkg::*;

   localparam int DEN_W  = (COUNT_WIDTH > DESIGN_W) ? COUNT_WIDTH : DESIGN_W;
   localparam int PROD_W = COUNT_WIDTH + PERIOD_W;

   state_type              state_ff, state_in;
   logic [PERIOD_W-1:0]    period_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [PROD_W-1:0]      runtime_ff;
   logic [PEAK_W-1:0]      avg_ff;
   logic [15:0]            health_ff;

   acc_ctrl_type           acc_ctrl;
   logic [COUNT_WIDTH-1:0] sample_counter;
   logic [15:0]            lowest_voltage;
   logic [15:0]            highest_temperature;
   logic [SUM_W-1:0]       discharge_sum;
   logic [COUNT_WIDTH-1:0] discharge_count;
   logic [PEAK_W-1:0]      discharge_peak;
   logic [DELIVERED_W-1:0] delivered_sum;
   logic [DESIGN_W-1:0]    latest_design;

   logic                   div_start;
   logic                   div_done;
   logic [SUM_W-1:0]       div_num;
   logic [DEN_W-1:0]       div_den;
   logic [SUM_W-1:0]       div_quo;
   logic                   req_fire;
   logic                   rsp_load;
   logic [SUM_W-1:0]       count_ext;
   logic [SUM_W-1:0]       runtime_ext;

   bds_accum #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_accum (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (acc_ctrl),
      .sample              (req_data),
      .sample_counter      (sample_counter),
      .lowest_voltage      (lowest_voltage),
      .highest_temperature (highest_temperature),
      .discharge_sum       (discharge_sum),
      .discharge_count     (discharge_count),
      .discharge_peak      (discharge_peak),
      .delivered_sum       (delivered_sum),
      .latest_design       (latest_design)
   );

   always_comb begin
      if (state_ff == ST_HEALTH_START) begin
         div_num = SUM_W'(delivered_sum) * SUM_W'(PERMILLE);
         div_den = DEN_W'(latest_design);
      end else begin
         div_num = discharge_sum;
         div_den = DEN_W'(discharge_count);
      end
   end

   bds_divider #(
      .NUM_W(SUM_W),
      .DEN_W(DEN_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      count_ext   = SUM_W'(sample_counter);
      runtime_ext = SUM_W'(runtime_ff);
      rsp_data_in = '0;
      if (sample_counter >= COUNT_WIDTH'(2)) begin
         rsp_data_in.report_valid           = 1'b1;
         rsp_data_in.sample_total           = (count_ext > SUM_W'(MAX32)) ?
                                              MAX32 : count_ext[31:0];
         rsp_data_in.runtime_s              = (runtime_ext > SUM_W'(MAX32)) ?
                                              MAX32 : runtime_ext[31:0];
         rsp_data_in.delivered_energy_mwh   = delivered_sum;
         rsp_data_in.avg_discharge_mw       = avg_ff;
         rsp_data_in.max_discharge_mw       = discharge_peak;
         rsp_data_in.min_voltage_out_mv     = lowest_voltage;
         rsp_data_in.max_temperature_out_dk = highest_temperature;
         rsp_data_in.health_tenth_pct       = health_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      div_start      = 1'b0;
      rsp_load       = 1'b0;
      acc_ctrl.sample = req_fire;
      acc_ctrl.clear  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.last_sample) begin
               state_in = ST_AVG_START;
            end
         end
         ST_AVG_START: begin
            if (discharge_count != '0) begin
               div_start = 1'b1;
               state_in  = ST_AVG_WAIT;
            end else begin
               state_in  = ST_HEALTH_START;
            end
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               state_in = ST_HEALTH_START;
            end
         end
         ST_HEALTH_START: begin
            if (latest_design != '0) begin
               div_start = 1'b1;
               state_in  = ST_HEALTH_WAIT;
            end else begin
               state_in  = ST_EMIT;
            end
         end
         ST_HEALTH_WAIT: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load       = 1'b1;
               acc_ctrl.clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            period_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (state_ff == ST_AVG_START) begin
         runtime_ff <= PROD_W'(sample_counter - COUNT_WIDTH'(1)) * PROD_W'(period_ff);
         avg_ff     <= '0;
      end else if (state_ff == ST_AVG_WAIT && div_done) begin
         avg_ff <= (div_quo[SUM_W-1:PEAK_W] != '0) ? MAX31 : div_quo[PEAK_W-1:0];
      end
      if (state_ff == ST_HEALTH_START) begin
         health_ff <= '0;
      end else if (state_ff == ST_HEALTH_WAIT && div_done) begin
         health_ff <= (div_quo[SUM_W-1:16] != '0) ? HEALTH_MAX : div_quo[15:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_AVG_WAIT || state_ff == ST_HEALTH_WAIT))
      else $error("divider finished outside a wait state");

   a_last_starts_report: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.last_sample) |=> (state_ff == ST_AVG_START))
      else $error("closing request did not start a report");

   a_clear_after_report: assert property (@(posedge clock) disable iff (reset)
      acc_ctrl.clear |=> (sample_counter == '0 && rsp_valid_ff))
      else $error("statistics not cleared or report missing after load");

   a_no_sample_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !acc_ctrl.sample)
      else $error("sample folded in while a report is in progress");

endmodule

`default_nettype wire
